// File: hdl/triangle_plane_slice_macros.svh
// Assertion macros for the slicer port checker
`ifndef TRIANGLE_PLANE_SLICE_MACROS_SVH
`define TRIANGLE_PLANE_SLICE_MACROS_SVH
// Same-cycle implication, off during reset
`define TPS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, off during reset
`define TPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
// Next-cycle implication that also holds across reset
`define TPS_ASSERT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);
`endif

// File: hdl/tps_pkg.sv
// Shared constants and types of the triangle plane slicer
package tps_pkg;

  // Exit codes of a segment
  localparam logic [1:0] KIND_EDGE0  = 2'd0;
  localparam logic [1:0] KIND_EDGE1  = 2'd1;
  localparam logic [1:0] KIND_EDGE2  = 2'd2;
  localparam logic [1:0] KIND_VERTEX = 2'd3;

  // Register index decoded from paddr
  localparam logic REG_SLICE_Z = 1'b0;

  // Back-end sequencer states
  typedef enum logic [5:0] {
    B_IDLE = 6'b000001,
    B_SX   = 6'b000010,
    B_SY   = 6'b000100,
    B_EX   = 6'b001000,
    B_EY   = 6'b010000,
    B_FIN  = 6'b100000
  } bstate_t;

  // Interpolator phases
  typedef enum logic [4:0] {
    L_IDLE = 5'b00001,
    L_MUL  = 5'b00010,
    L_ADJ  = 5'b00100,
    L_DIV  = 5'b01000,
    L_FIN  = 5'b10000
  } lphase_t;

endpackage

// File: hdl/tps_front.sv
// Front end: classify a triangle against the plane and queue the work
module tps_front #(
  parameter int W = 25
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic signed [W-1:0]   slice_z,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_new_chain,
  input  logic signed [W-1:0]   in_v0_x,
  input  logic signed [W-1:0]   in_v0_y,
  input  logic signed [W-1:0]   in_v0_z,
  input  logic signed [W-1:0]   in_v1_x,
  input  logic signed [W-1:0]   in_v1_y,
  input  logic signed [W-1:0]   in_v1_z,
  input  logic signed [W-1:0]   in_v2_x,
  input  logic signed [W-1:0]   in_v2_y,
  input  logic signed [W-1:0]   in_v2_z,
  input  logic                  q_pop,
  output logic                  q_valid,
  output logic [5+10*W-1:0]     q_data
);

  typedef struct packed {
    logic                match;
    logic                new_chain;
    logic                snap;
    logic [1:0]          kind;
    logic signed [W-1:0] ax, ay, az, bx, by, bz, cx, cy, cz, zs;
  } tent_t;

  tent_t       ent;
  tent_t       mem_r [2];
  logic        wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        push;
  logic        lt0, lt1, lt2, gt0, gt1, gt2;
  logic [1:0]  ia, ib, ic;
  logic signed [W-1:0] vx [3];
  logic signed [W-1:0] vy [3];
  logic signed [W-1:0] vz [3];

  assign vx[0] = in_v0_x; assign vy[0] = in_v0_y; assign vz[0] = in_v0_z;
  assign vx[1] = in_v1_x; assign vy[1] = in_v1_y; assign vz[1] = in_v1_z;
  assign vx[2] = in_v2_x; assign vy[2] = in_v2_y; assign vz[2] = in_v2_z;

  assign lt0 = in_v0_z < slice_z;
  assign lt1 = in_v1_z < slice_z;
  assign lt2 = in_v2_z < slice_z;
  assign gt0 = in_v0_z > slice_z;
  assign gt1 = in_v1_z > slice_z;
  assign gt2 = in_v2_z > slice_z;

  // Pick the case: lone vertex a, start edge a-b, end edge a-c
  always_comb begin
    ent.match     = 1'b1;
    ent.new_chain = in_new_chain;
    ent.snap      = 1'b0;
    ent.kind      = tps_pkg::KIND_EDGE0;
    ia = 2'd0; ib = 2'd0; ic = 2'd0;
    if (lt0 && !lt1 && !lt2) begin
      ia = 2'd0; ib = 2'd2; ic = 2'd1; ent.kind = tps_pkg::KIND_EDGE0;
      ent.snap = !gt1;
    end else if (gt0 && lt1 && lt2) begin
      ia = 2'd0; ib = 2'd1; ic = 2'd2; ent.kind = tps_pkg::KIND_EDGE2;
    end else if (lt1 && !lt0 && !lt2) begin
      ia = 2'd1; ib = 2'd0; ic = 2'd2; ent.kind = tps_pkg::KIND_EDGE1;
      ent.snap = !gt2;
    end else if (gt1 && lt0 && lt2) begin
      ia = 2'd1; ib = 2'd2; ic = 2'd0; ent.kind = tps_pkg::KIND_EDGE0;
    end else if (lt2 && !lt1 && !lt0) begin
      ia = 2'd2; ib = 2'd1; ic = 2'd0; ent.kind = tps_pkg::KIND_EDGE2;
      ent.snap = !gt0;
    end else if (gt2 && lt1 && lt0) begin
      ia = 2'd2; ib = 2'd0; ic = 2'd1; ent.kind = tps_pkg::KIND_EDGE1;
    end else begin
      ent.match = 1'b0;
    end
    ent.ax = vx[ia]; ent.ay = vy[ia]; ent.az = vz[ia];
    ent.bx = vx[ib]; ent.by = vy[ib]; ent.bz = vz[ib];
    ent.cx = vx[ic]; ent.cy = vy[ic]; ent.cz = vz[ic];
    ent.zs = slice_z;
  end

  // Two-entry queue toward the back end
  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_data   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= ent;
    end
  end

endmodule

// File: hdl/tps_lerp.sv
// Shared interpolator: multiply, round by half divisor, bit-serial divide
module tps_lerp #(
  parameter int W = 25
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic signed [W-1:0] x,
  input  logic signed [W-1:0] x0,
  input  logic signed [W-1:0] x1,
  input  logic signed [W-1:0] y0,
  input  logic signed [W-1:0] y1,
  output logic                done,
  output logic [W-1:0]        res
);

  localparam int DW = W + 1;
  localparam int PW = 2 * DW;
  localparam int NW = PW + 1;
  localparam int CW = $clog2(NW + 1);

  tps_pkg::lphase_t ph_r, ph_nxt;
  logic signed [DW-1:0] d_r, d_nxt, dy_r, dy_nxt, dx_r, dx_nxt;
  logic        [W-1:0]  y0_r, y0_nxt;
  logic signed [PW-1:0] n_r, n_nxt;
  logic        [DW-1:0] dmag_r, dmag_nxt, rem_r, rem_nxt;
  logic        [NW-1:0] dq_r, dq_nxt;
  logic                 neg_r, neg_nxt;
  logic        [CW-1:0] cnt_r, cnt_nxt;
  logic        [W-1:0]  res_r, res_nxt;
  logic                 done_r, done_nxt;

  logic        [DW-1:0] dabs;
  logic signed [NW-1:0] half_s, n_ext, n2;
  logic        [DW:0]   rem_sh;
  logic                 ge;
  logic        [W-1:0]  qlow;

  assign done = done_r;
  assign res  = res_r;

  always_comb begin
    ph_nxt   = ph_r;
    d_nxt    = d_r;
    dy_nxt   = dy_r;
    dx_nxt   = dx_r;
    y0_nxt   = y0_r;
    n_nxt    = n_r;
    dmag_nxt = dmag_r;
    rem_nxt  = rem_r;
    dq_nxt   = dq_r;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    res_nxt  = res_r;
    done_nxt = 1'b0;

    dabs   = d_r[DW-1] ? DW'(-d_r) : DW'(d_r);
    half_s = d_r[DW-1] ? -NW'({1'b0, dabs >> 1}) : NW'({1'b0, dabs >> 1});
    n_ext  = NW'(n_r);
    n2     = (n_r > 0) ? (n_ext + half_s) : (n_ext - half_s);
    rem_sh = {rem_r, dq_r[NW-1]};
    ge     = (rem_sh >= {1'b0, dmag_r});
    qlow   = neg_r ? W'(-dq_r[W-1:0]) : dq_r[W-1:0];

    case (ph_r)
      tps_pkg::L_IDLE: begin
        if (start) begin
          d_nxt  = DW'(x1) - DW'(x0);
          dy_nxt = DW'(y1) - DW'(y0);
          dx_nxt = DW'(x) - DW'(x0);
          y0_nxt = y0;
          ph_nxt = tps_pkg::L_MUL;
        end
      end
      tps_pkg::L_MUL: begin
        n_nxt  = PW'(dy_r) * PW'(dx_r);
        ph_nxt = tps_pkg::L_ADJ;
      end
      tps_pkg::L_ADJ: begin
        // Offset by half the divisor (added for a positive product, else subtracted), then split sign and magnitude
        neg_nxt  = n2[NW-1] ^ d_r[DW-1];
        dq_nxt   = n2[NW-1] ? NW'(-n2) : NW'(n2);
        dmag_nxt = dabs;
        rem_nxt  = '0;
        cnt_nxt  = '0;
        ph_nxt   = tps_pkg::L_DIV;
      end
      tps_pkg::L_DIV: begin
        // One quotient bit a cycle
        rem_nxt = ge ? DW'(rem_sh - {1'b0, dmag_r}) : rem_sh[DW-1:0];
        dq_nxt  = {dq_r[NW-2:0], ge};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CW'(NW - 1)) begin
          ph_nxt = tps_pkg::L_FIN;
        end
      end
      tps_pkg::L_FIN: begin
        res_nxt  = y0_r + qlow;
        done_nxt = 1'b1;
        ph_nxt   = tps_pkg::L_IDLE;
      end
      default: begin
        ph_nxt = tps_pkg::L_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= tps_pkg::L_IDLE;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      ph_r   <= ph_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    d_r    <= d_nxt;
    dy_r   <= dy_nxt;
    dx_r   <= dx_nxt;
    y0_r   <= y0_nxt;
    n_r    <= n_nxt;
    dmag_r <= dmag_nxt;
    rem_r  <= rem_nxt;
    dq_r   <= dq_nxt;
    neg_r  <= neg_nxt;
    res_r  <= res_nxt;
  end

endmodule

// File: hdl/tps_back.sv
// Back end: sequence the interpolations, keep chain state, drive results
module tps_back #(
  parameter int W = 25
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  logic [5+10*W-1:0]   q_data,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_hit,
  output logic signed [W-1:0] out_seg_start_x,
  output logic signed [W-1:0] out_seg_start_y,
  output logic signed [W-1:0] out_seg_end_x,
  output logic signed [W-1:0] out_seg_end_y,
  output logic [1:0]          out_exit_kind
);

  typedef struct packed {
    logic                match;
    logic                new_chain;
    logic                snap;
    logic [1:0]          kind;
    logic signed [W-1:0] ax, ay, az, bx, by, bz, cx, cy, cz, zs;
  } tent_t;

  tps_pkg::bstate_t st_r, st_nxt;
  tent_t            ent_r, ent_nxt, qe;
  logic             chain_r, chain_nxt;
  logic [W-1:0]     lx_r, lx_nxt, ly_r, ly_nxt;
  logic [W-1:0]     sx_r, sx_nxt, sy_r, sy_nxt, ex_r, ex_nxt, ey_r, ey_nxt;
  logic             go_r, go_nxt;
  logic             ov_r, ov_nxt, oh_r, oh_nxt;
  logic [W-1:0]     osx_r, osx_nxt, osy_r, osy_nxt, oex_r, oex_nxt, oey_r, oey_nxt;
  logic [1:0]       ok_r, ok_nxt;

  logic signed [W-1:0] l_x1, l_y0, l_y1;
  logic                l_done;
  logic [W-1:0]        l_res;
  logic                slot_free, moved;

  assign qe        = q_data;
  assign slot_free = !ov_r || !out_stall;

  // Operand select for the shared interpolator
  always_comb begin
    l_x1 = ent_r.bz;
    l_y0 = ent_r.ax;
    l_y1 = ent_r.bx;
    case (st_r)
      tps_pkg::B_SY: begin l_x1 = ent_r.bz; l_y0 = ent_r.ay; l_y1 = ent_r.by; end
      tps_pkg::B_EX: begin l_x1 = ent_r.cz; l_y0 = ent_r.ax; l_y1 = ent_r.cx; end
      tps_pkg::B_EY: begin l_x1 = ent_r.cz; l_y0 = ent_r.ay; l_y1 = ent_r.cy; end
      default: begin l_x1 = ent_r.bz; l_y0 = ent_r.ax; l_y1 = ent_r.bx; end
    endcase
  end

  tps_lerp #(.W(W)) u_lerp (
    .clk   (clk),
    .rst_n (rst_n),
    .start (go_r),
    .x     (ent_r.zs),
    .x0    (ent_r.az),
    .x1    (l_x1),
    .y0    (l_y0),
    .y1    (l_y1),
    .done  (l_done),
    .res   (l_res)
  );

  always_comb begin
    st_nxt    = st_r;
    ent_nxt   = ent_r;
    chain_nxt = chain_r;
    lx_nxt    = lx_r;
    ly_nxt    = ly_r;
    sx_nxt    = sx_r;
    sy_nxt    = sy_r;
    ex_nxt    = ex_r;
    ey_nxt    = ey_r;
    go_nxt    = 1'b0;
    q_pop     = 1'b0;
    oh_nxt    = oh_r;
    osx_nxt   = osx_r;
    osy_nxt   = osy_r;
    oex_nxt   = oex_r;
    oey_nxt   = oey_r;
    ok_nxt    = ok_r;
    moved     = (ex_r != sx_r) || (ey_r != sy_r);
    ov_nxt    = out_stall ? ov_r : 1'b0;

    case (st_r)
      tps_pkg::B_IDLE: begin
        if (q_valid) begin
          // Take the next item; a new chain drops the stored end first
          q_pop   = 1'b1;
          ent_nxt = qe;
          if (qe.new_chain) begin
            chain_nxt = 1'b0;
            lx_nxt    = '0;
            ly_nxt    = '0;
          end
          if (!qe.match) begin
            st_nxt = tps_pkg::B_FIN;
          end else if (chain_r && !qe.new_chain) begin
            sx_nxt = lx_r;
            sy_nxt = ly_r;
            go_nxt = 1'b1;
            st_nxt = tps_pkg::B_EX;
          end else begin
            go_nxt = 1'b1;
            st_nxt = tps_pkg::B_SX;
          end
        end
      end
      tps_pkg::B_SX: begin
        if (l_done) begin
          sx_nxt = l_res; go_nxt = 1'b1; st_nxt = tps_pkg::B_SY;
        end
      end
      tps_pkg::B_SY: begin
        if (l_done) begin
          sy_nxt = l_res; go_nxt = 1'b1; st_nxt = tps_pkg::B_EX;
        end
      end
      tps_pkg::B_EX: begin
        if (l_done) begin
          ex_nxt = l_res; go_nxt = 1'b1; st_nxt = tps_pkg::B_EY;
        end
      end
      tps_pkg::B_EY: begin
        if (l_done) begin
          ey_nxt = l_res; st_nxt = tps_pkg::B_FIN;
        end
      end
      tps_pkg::B_FIN: begin
        if (slot_free) begin
          // Resolve vertex snap, update chain, load the output beat
          ov_nxt  = 1'b1;
          oh_nxt  = 1'b0;
          osx_nxt = '0;
          osy_nxt = '0;
          oex_nxt = '0;
          oey_nxt = '0;
          ok_nxt  = tps_pkg::KIND_EDGE0;
          if (ent_r.match) begin
            lx_nxt = ex_r;
            ly_nxt = ey_r;
            if (ent_r.snap) begin
              if (moved) begin
                // Stored end follows the snapped vertex
                lx_nxt  = ent_r.cx;
                ly_nxt  = ent_r.cy;
                oh_nxt  = 1'b1;
                osx_nxt = sx_r;
                osy_nxt = sy_r;
                oex_nxt = ent_r.cx;
                oey_nxt = ent_r.cy;
                ok_nxt  = tps_pkg::KIND_VERTEX;
              end
            end else begin
              chain_nxt = 1'b1;
              oh_nxt    = 1'b1;
              osx_nxt   = sx_r;
              osy_nxt   = sy_r;
              oex_nxt   = ex_r;
              oey_nxt   = ey_r;
              ok_nxt    = ent_r.kind;
            end
          end
          st_nxt = tps_pkg::B_IDLE;
        end
      end
      default: begin
        st_nxt = tps_pkg::B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= tps_pkg::B_IDLE;
      chain_r <= 1'b0;
      lx_r    <= '0;
      ly_r    <= '0;
      go_r    <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      chain_r <= chain_nxt;
      lx_r    <= lx_nxt;
      ly_r    <= ly_nxt;
      go_r    <= go_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
    sx_r  <= sx_nxt;
    sy_r  <= sy_nxt;
    ex_r  <= ex_nxt;
    ey_r  <= ey_nxt;
    oh_r  <= oh_nxt;
    osx_r <= osx_nxt;
    osy_r <= osy_nxt;
    oex_r <= oex_nxt;
    oey_r <= oey_nxt;
    ok_r  <= ok_nxt;
  end

  assign out_valid       = ov_r;
  assign out_hit         = oh_r;
  assign out_seg_start_x = osx_r;
  assign out_seg_start_y = osy_r;
  assign out_seg_end_x   = oex_r;
  assign out_seg_end_y   = oey_r;
  assign out_exit_kind   = ok_r;

endmodule

// File: hdl/triangle_plane_slice.sv
// Top level of the triangle plane slicer
//
//  Port group  Direction  Handshake          Beat
//  in_*        input      in_valid/in_stall  one triangle, three vertices
//  out_*       output     out_valid/out_stall one segment or a no-hit beat
//  APB         input      psel/penable       slice_z at byte address 0
//
// A triangle with no crossing goes straight to the final step of the back end. A
// crossing triangle runs four interpolations (two when the chain is open) through
// one shared unit with a one-bit-a-cycle divider. A two-entry queue lets the
// front take items while the back works. Reset is synchronous and clears slice_z
// and the chain state.
// A stalled output holds its beat; the back end waits in its final step.
module triangle_plane_slice #(
  parameter int COORD_BITS = 25
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_new_chain,
  input  logic signed [COORD_BITS-1:0] in_v0_x,
  input  logic signed [COORD_BITS-1:0] in_v0_y,
  input  logic signed [COORD_BITS-1:0] in_v0_z,
  input  logic signed [COORD_BITS-1:0] in_v1_x,
  input  logic signed [COORD_BITS-1:0] in_v1_y,
  input  logic signed [COORD_BITS-1:0] in_v1_z,
  input  logic signed [COORD_BITS-1:0] in_v2_x,
  input  logic signed [COORD_BITS-1:0] in_v2_y,
  input  logic signed [COORD_BITS-1:0] in_v2_z,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_hit,
  output logic signed [COORD_BITS-1:0] out_seg_start_x,
  output logic signed [COORD_BITS-1:0] out_seg_start_y,
  output logic signed [COORD_BITS-1:0] out_seg_end_x,
  output logic signed [COORD_BITS-1:0] out_seg_end_y,
  output logic [1:0]                   out_exit_kind
);

  localparam int EW = 5 + 10 * COORD_BITS;

  logic signed [COORD_BITS-1:0] slice_z_r, slice_z_nxt;
  logic                         q_valid, q_pop;
  logic [EW-1:0]                q_data;
  logic                         wr_en;

  // Configuration write and read-back
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready && (paddr[2] == tps_pkg::REG_SLICE_Z);
  assign slice_z_nxt = wr_en ? pwdata[COORD_BITS-1:0] : slice_z_r;
  assign prdata = (paddr[2] == tps_pkg::REG_SLICE_Z) ?
                  {{(32-COORD_BITS){slice_z_r[COORD_BITS-1]}}, slice_z_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slice_z_r <= '0;
    end else begin
      slice_z_r <= slice_z_nxt;
    end
  end

  tps_front #(.W(COORD_BITS)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .slice_z      (slice_z_r),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_new_chain (in_new_chain),
    .in_v0_x      (in_v0_x),
    .in_v0_y      (in_v0_y),
    .in_v0_z      (in_v0_z),
    .in_v1_x      (in_v1_x),
    .in_v1_y      (in_v1_y),
    .in_v1_z      (in_v1_z),
    .in_v2_x      (in_v2_x),
    .in_v2_y      (in_v2_y),
    .in_v2_z      (in_v2_z),
    .q_pop        (q_pop),
    .q_valid      (q_valid),
    .q_data       (q_data)
  );

  tps_back #(.W(COORD_BITS)) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_data          (q_data),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_hit         (out_hit),
    .out_seg_start_x (out_seg_start_x),
    .out_seg_start_y (out_seg_start_y),
    .out_seg_end_x   (out_seg_end_x),
    .out_seg_end_y   (out_seg_end_y),
    .out_exit_kind   (out_exit_kind)
  );

endmodule

// File: hdl/tps_checker.sv
// Port-level checks of the triangle plane slicer, bound to the top level
`include "triangle_plane_slice_macros.svh"
module tps_checker #(
  parameter int W = 25
) (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input logic                out_hit,
  input logic signed [W-1:0] out_seg_start_x,
  input logic signed [W-1:0] out_seg_start_y,
  input logic signed [W-1:0] out_seg_end_x,
  input logic signed [W-1:0] out_seg_end_y,
  input logic [1:0]          out_exit_kind
);

  // No-hit beats carry zeros
  `TPS_ASSERT_NOW(a_nohit_zero, out_valid && !out_hit, (out_seg_start_x == 0) && (out_seg_start_y == 0) && (out_seg_end_x == 0) && (out_seg_end_y == 0) && (out_exit_kind == tps_pkg::KIND_EDGE0), "no-hit beat has nonzero fields")
  // A vertex end only comes with a hit
  `TPS_ASSERT_NOW(a_vertex_hit, out_valid && (out_exit_kind == tps_pkg::KIND_VERTEX), out_hit, "vertex end on a no-hit beat")
  // Results leave reset empty
  `TPS_ASSERT_ALWAYS(a_reset_idle, !rst_n, !out_valid && !in_stall, "output or stall active after reset")
  // A stalled beat holds
  `TPS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_seg_end_x) && $stable(out_exit_kind), "stalled beat changed")

endmodule

bind triangle_plane_slice tps_checker #(.W(COORD_BITS)) u_tps_checker (.*);

// File: tb/tb_triangle_plane_slice.sv
// Self-checking testbench for the triangle plane slicer: directed and random triangles
`timescale 1ns / 1ps

module tb_triangle_plane_slice;

  localparam int CB = 25;
  localparam longint CMAX = (longint'(1) <<< (CB - 1)) - 1;
  localparam longint CMIN = -(longint'(1) <<< (CB - 1));
  localparam int LIMIT_CYCLES = 4000000;
  localparam int DRAIN_CYCLES = 300;

  typedef logic signed [CB-1:0] coord_t;

  typedef struct {
    logic   new_chain;
    coord_t x[3];
    coord_t y[3];
    coord_t z[3];
  } tri_t;

  typedef struct {
    logic       hit;
    coord_t     sx;
    coord_t     sy;
    coord_t     ex;
    coord_t     ey;
    logic [1:0] kind;
  } seg_t;

  // Slicer model plus the queue of segments it still expects
  class slice_scoreboard;
    seg_t   segs_due[$];
    longint plane_z;
    longint end_x;
    longint end_y;
    bit     chain_on;
    int     errors;
    int     hits;

    function new();
      plane_z  = 0;
      end_x    = 0;
      end_y    = 0;
      chain_on = 0;
      errors   = 0;
      hits     = 0;
    endfunction

    // Interpolate y over x; half-divisor rounding, truncating divide
    function longint lerp(longint x, longint x0, longint x1, longint y0, longint y1);
      longint d;
      longint n;
      d = x1 - x0;
      if (d == 0) return y0;
      n = (y1 - y0) * (x - x0);
      n = (n > 0) ? n + d / 2 : n - d / 2;
      return y0 + n / d;
    endfunction

    function void note_triangle(tri_t t);
      longint vx[3], vy[3], vz[3];
      longint sxv, syv, exv, eyv;
      int a, b, c, snap;
      logic [1:0] kind;
      bit match, hit;
      seg_t s;
      if (t.new_chain) begin
        end_x = 0; end_y = 0; chain_on = 0;
      end
      for (int i = 0; i < 3; i++) begin
        vx[i] = t.x[i]; vy[i] = t.y[i]; vz[i] = t.z[i];
      end
      match = 1; hit = 0; snap = -1; a = 0; b = 0; c = 0; kind = tps_pkg::KIND_EDGE0;
      sxv = 0; syv = 0; exv = 0; eyv = 0;
      if (vz[0] < plane_z && vz[1] >= plane_z && vz[2] >= plane_z) begin
        a = 0; b = 2; c = 1; kind = tps_pkg::KIND_EDGE0;
        if (vz[1] == plane_z) snap = 1;
      end else if (vz[0] > plane_z && vz[1] < plane_z && vz[2] < plane_z) begin
        a = 0; b = 1; c = 2; kind = tps_pkg::KIND_EDGE2;
      end else if (vz[1] < plane_z && vz[0] >= plane_z && vz[2] >= plane_z) begin
        a = 1; b = 0; c = 2; kind = tps_pkg::KIND_EDGE1;
        if (vz[2] == plane_z) snap = 2;
      end else if (vz[1] > plane_z && vz[0] < plane_z && vz[2] < plane_z) begin
        a = 1; b = 2; c = 0; kind = tps_pkg::KIND_EDGE0;
      end else if (vz[2] < plane_z && vz[1] >= plane_z && vz[0] >= plane_z) begin
        a = 2; b = 1; c = 0; kind = tps_pkg::KIND_EDGE2;
        if (vz[0] == plane_z) snap = 0;
      end else if (vz[2] > plane_z && vz[1] < plane_z && vz[0] < plane_z) begin
        a = 2; b = 0; c = 1; kind = tps_pkg::KIND_EDGE1;
      end else begin
        match = 0;
      end
      if (match) begin
        if (chain_on) begin
          sxv = end_x; syv = end_y;
        end else begin
          sxv = lerp(plane_z, vz[a], vz[b], vx[a], vx[b]);
          syv = lerp(plane_z, vz[a], vz[b], vy[a], vy[b]);
        end
        exv = lerp(plane_z, vz[a], vz[c], vx[a], vx[c]);
        eyv = lerp(plane_z, vz[a], vz[c], vy[a], vy[c]);
        if (snap >= 0) begin
          // vertex on the plane: snap the end, drop a collapsed segment
          if (exv != sxv || eyv != syv) begin
            exv = vx[snap]; eyv = vy[snap]; kind = tps_pkg::KIND_VERTEX; hit = 1;
          end
        end else begin
          hit = 1; chain_on = 1;
        end
        end_x = exv; end_y = eyv;
      end
      s.hit = hit;
      s.sx = hit ? coord_t'(sxv) : '0;
      s.sy = hit ? coord_t'(syv) : '0;
      s.ex = hit ? coord_t'(exv) : '0;
      s.ey = hit ? coord_t'(eyv) : '0;
      s.kind = hit ? kind : tps_pkg::KIND_EDGE0;
      segs_due.insert(segs_due.size(), s);
    endfunction

    task report(string what, longint got, longint want);
      errors++;
      $display("MISMATCH %s: got %0d expected %0d", what, got, want);
    endtask

    task check_segment(seg_t r);
      seg_t e;
      if (segs_due.size() == 0) begin
        report("unexpected segment beat", 1, 0);
        return;
      end
      e = segs_due.pop_front();
      if (r.hit) hits++;
      if (r.hit !== e.hit) report("hit", r.hit, e.hit);
      if (r.sx !== e.sx) report("seg_start_x", r.sx, e.sx);
      if (r.sy !== e.sy) report("seg_start_y", r.sy, e.sy);
      if (r.ex !== e.ex) report("seg_end_x", r.ex, e.ex);
      if (r.ey !== e.ey) report("seg_end_y", r.ey, e.ey);
      if (r.kind !== e.kind) report("exit_kind", r.kind, e.kind);
    endtask
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 0;
  logic in_stall;
  logic in_new_chain = 0;
  coord_t in_v0_x = '0, in_v0_y = '0, in_v0_z = '0;
  coord_t in_v1_x = '0, in_v1_y = '0, in_v1_z = '0;
  coord_t in_v2_x = '0, in_v2_y = '0, in_v2_z = '0;
  logic out_valid;
  logic out_stall = 0;
  logic out_hit;
  coord_t out_seg_start_x, out_seg_start_y, out_seg_end_x, out_seg_end_y;
  logic [1:0] out_exit_kind;

  slice_scoreboard sb = new();
  int idle_pct = 0;
  int stall_pct = 0;
  int sent = 0;
  int cycles = 0;
  longint cur_z = 0;

  triangle_plane_slice #(.COORD_BITS(CB)) uut (.*);

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver: random stall, check each accepted beat
  always @(negedge clk) out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);

  always @(posedge clk) begin
    seg_t r;
    if (rst_n && out_valid && !out_stall) begin
      r.hit = out_hit; r.sx = out_seg_start_x; r.sy = out_seg_start_y;
      r.ex = out_seg_end_x; r.ey = out_seg_end_y; r.kind = out_exit_kind;
      sb.check_segment(r);
    end
  end

  function coord_t clampc(longint v);
    if (v > CMAX) return coord_t'(CMAX);
    if (v < CMIN) return coord_t'(CMIN);
    return coord_t'(v);
  endfunction

  function coord_t rnd_full();
    return coord_t'($urandom);
  endfunction

  task send_triangle(tri_t t);
    // idle the sender for a random gap first
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) @(negedge clk);
    in_valid = 1;
    in_new_chain = t.new_chain;
    in_v0_x = t.x[0]; in_v0_y = t.y[0]; in_v0_z = t.z[0];
    in_v1_x = t.x[1]; in_v1_y = t.y[1]; in_v1_z = t.z[1];
    in_v2_x = t.x[2]; in_v2_y = t.y[2]; in_v2_z = t.z[2];
    do @(posedge clk); while (in_stall);
    sb.note_triangle(t);
    sent++;
    @(negedge clk);
    in_valid = 0;
  endtask

  // Hold off until every segment is back, then let the back end settle
  task drain();
    while (sb.segs_due.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task write_plane(longint zval);
    drain();
    psel = 1; pwrite = 1; penable = 0; paddr = '0; pwdata = 32'(zval);
    @(negedge clk);
    penable = 1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 0; penable = 0; pwrite = 0;
    sb.plane_z = coord_t'(zval);
    cur_z = coord_t'(zval);
  endtask

  function tri_t mk(bit nc, longint ax, longint ay, longint az, longint bx, longint by,
                    longint bz, longint cx, longint cy, longint cz);
    tri_t t;
    t.new_chain = nc;
    t.x[0] = clampc(ax); t.y[0] = clampc(ay); t.z[0] = clampc(az);
    t.x[1] = clampc(bx); t.y[1] = clampc(by); t.z[1] = clampc(bz);
    t.x[2] = clampc(cx); t.y[2] = clampc(cy); t.z[2] = clampc(cz);
    return t;
  endfunction

  // Triangle around the plane: each vertex below, above or exactly on it
  function tri_t random_crossing();
    tri_t t;
    longint span;
    int sel;
    sel = $urandom_range(9);
    span = (sel < 5) ? 64 : (sel < 9) ? 4096 : CMAX;
    t.new_chain = ($urandom_range(7) == 0);
    for (int i = 0; i < 3; i++) begin
      case ($urandom_range(4))
        0, 1: t.z[i] = clampc(cur_z - 1 - longint'($urandom_range(32'(span))));
        2, 3: t.z[i] = clampc(cur_z + 1 + longint'($urandom_range(32'(span))));
        default: t.z[i] = coord_t'(cur_z);
      endcase
      if (sel == 9) begin
        t.x[i] = rnd_full(); t.y[i] = rnd_full();
      end else begin
        t.x[i] = clampc(longint'($urandom_range(32'(2 * span))) - span);
        t.y[i] = clampc(longint'($urandom_range(32'(2 * span))) - span);
      end
    end
    return t;
  endfunction

  function tri_t random_noise();
    tri_t t;
    t.new_chain = 1'($urandom_range(1));
    for (int i = 0; i < 3; i++) begin
      t.x[i] = rnd_full(); t.y[i] = rnd_full(); t.z[i] = rnd_full();
    end
    return t;
  endfunction

  task run_phase(int idle, int stall, int count);
    idle_pct = idle;
    stall_pct = stall;
    for (int i = 0; i < count; i++)
      send_triangle(($urandom_range(9) < 8) ? random_crossing() : random_noise());
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst_n = 1;
    @(negedge clk);

    // Directed: each crossing case, vertex snaps, collapse, misses, extremes
    send_triangle(mk(1, 0, 0, -10, 100, 50, 10, -40, 80, 30));
    send_triangle(mk(0, 7, 3, 20, -9, 4, -5, 60, -60, -15));
    send_triangle(mk(1, 10, 10, 5, 0, 0, -5, 30, -30, 15));
    send_triangle(mk(1, 1, 2, -7, 90, 9, 3, -3, 33, -1));
    send_triangle(mk(1, 5, 5, 4, 6, 6, 8, -9, -2, -6));
    send_triangle(mk(1, 1, 1, -3, -2, -8, -4, 11, 17, 9));
    send_triangle(mk(1, 0, 0, -10, 20, 30, 0, 50, 40, 10));
    send_triangle(mk(1, 15, 25, 0, 0, 0, -10, 60, 40, 10));
    send_triangle(mk(1, 12, 13, 0, 40, 40, 10, 0, 0, -10));
    send_triangle(mk(1, 0, 0, -10, 5, 5, 0, 5, 5, 0));
    send_triangle(mk(1, 0, 0, 10, 1, 1, 20, 2, 2, 30));
    send_triangle(mk(0, 0, 0, 0, 1, 1, 0, 2, 2, 0));
    send_triangle(mk(0, 0, 0, -1, 1, 1, -2, 2, 2, -3));
    send_triangle(mk(1, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMAX, CMAX, CMAX));
    send_triangle(mk(0, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMIN, CMIN, CMIN));
    send_triangle(mk(1, CMAX, CMAX, -1, CMIN, CMIN, 1, CMIN, CMAX, CMAX));
    send_triangle(mk(0, -1, -1, CMIN, 0, 0, CMAX, -1, 0, 1));
    write_plane(CMAX);
    send_triangle(mk(1, 3, 4, CMAX - 5, 9, 9, CMAX, -7, 2, CMAX));
    send_triangle(mk(1, 3, 4, CMAX, 9, 9, CMAX - 1, -7, 2, CMAX));
    write_plane(CMIN);
    send_triangle(mk(1, 3, 4, CMIN, 9, 9, CMIN + 3, -7, 2, CMIN + 1));
    send_triangle(mk(1, CMIN, CMAX, CMIN + 8, CMAX, CMIN, CMIN, 0, 0, CMIN));
    write_plane(-1234567);

    // Random phases at several plane heights
    run_phase(0, 0, 480);
    write_plane(longint'($urandom_range(32'h1FF_FFFF)) - (longint'(1) <<< 24));
    run_phase(84, 0, 480);
    write_plane(CMIN);
    run_phase(0, 84, 120);
    write_plane(0);
    run_phase(0, 84, 380);
    write_plane(CMAX);
    run_phase(10, 10, 120);
    write_plane(777);
    run_phase(10, 10, 350);

    idle_pct = 0;
    while (sb.segs_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Sent %0d triangles over six plane heights and four flow-control phases;",
             sent);
    $display("%0d segments came back as hits, %0d mismatches.", sb.hits, sb.errors);
    if (sb.errors == 0 && sb.segs_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hdl
hdl/tps_pkg.sv
hdl/tps_front.sv
hdl/tps_lerp.sv
hdl/tps_back.sv
hdl/triangle_plane_slice.sv
hdl/tps_checker.sv
tb/tb_triangle_plane_slice.sv
